[hw/rtl/psws_pkg.sv]
package psws_pkg;

	localparam logic [1:0] OP_MIDI   = 2'd0;
	localparam logic [1:0] OP_FRAME  = 2'd1;
	localparam logic [1:0] OP_ALLOFF = 2'd2;

	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;

	// Q48 phase increment of note 0 at 48 kHz
	localparam logic [63:0] BASE_C0 = 64'd47943391863;
	localparam int Q48_W = 48;

	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = 2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [7:0]         status_byte;
		logic [6:0]         data_one;
		logic [6:0]         data_two;
		logic signed [31:0] left_in;
		logic signed [31:0] right_in;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] left_out;
		logic signed [31:0] right_out;
	} mix_item_t;

	typedef enum logic [1:0] {
		JOB_NOTE_ON  = 2'd0,
		JOB_NOTE_OFF = 2'd1,
		JOB_FRAME    = 2'd2,
		JOB_ALL_OFF  = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t          kind;
		logic [6:0]         note;
		logic [6:0]         velocity;
		logic [Q48_W-1:0]   inc_q48;
		logic signed [31:0] left_in;
		logic signed [31:0] right_in;
	} job_t;

	// (BASE_C0 * 2^(k/12) in Q24) >> 24, folded to constants
	function automatic logic [Q48_W-1:0] semi_base(input logic [3:0] k);
		logic [63:0] r;
		case (k)
			4'd0:    r = (BASE_C0 * 64'd16777216) >> 24;
			4'd1:    r = (BASE_C0 * 64'd17774841) >> 24;
			4'd2:    r = (BASE_C0 * 64'd18831788) >> 24;
			4'd3:    r = (BASE_C0 * 64'd19951585) >> 24;
			4'd4:    r = (BASE_C0 * 64'd21137968) >> 24;
			4'd5:    r = (BASE_C0 * 64'd22394897) >> 24;
			4'd6:    r = (BASE_C0 * 64'd23726567) >> 24;
			4'd7:    r = (BASE_C0 * 64'd25137422) >> 24;
			4'd8:    r = (BASE_C0 * 64'd26632170) >> 24;
			4'd9:    r = (BASE_C0 * 64'd28215802) >> 24;
			4'd10:   r = (BASE_C0 * 64'd29893600) >> 24;
			4'd11:   r = (BASE_C0 * 64'd31671168) >> 24;
			default: r = 64'd0;
		endcase
		return r[Q48_W-1:0];
	endfunction

endpackage

[hw/rtl/psws_ram.sv]
module psws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

[hw/rtl/psws_front.sv]
module psws_front (
	input  logic                  cmd_valid,
	input  psws_pkg::cmd_item_t   cmd,
	input  logic                  cmd_stall,
	output logic                  push,
	output psws_pkg::job_t        job
);

	logic [3:0]  nib;
	logic [12:0] oct_prod;
	logic [3:0]  oct;
	logic [6:0]  oct12;
	logic [6:0]  semi;
	logic        keep;

	assign nib = cmd.status_byte[7:4];

	// note / 12 by reciprocal, exact for 0..127
	assign oct_prod = 13'(cmd.data_one) * 13'd43;
	assign oct      = oct_prod[12:9];
	assign oct12    = 7'(oct) * 7'd12;
	assign semi     = cmd.data_one - oct12;

	always_comb begin
		keep         = 1'b0;
		job.kind     = psws_pkg::JOB_FRAME;
		job.note     = cmd.data_one;
		job.velocity = cmd.data_two;
		job.inc_q48  = psws_pkg::semi_base(semi[3:0]) << oct;
		job.left_in  = cmd.left_in;
		job.right_in = cmd.right_in;
		case (cmd.opcode)
			psws_pkg::OP_MIDI: begin
				if (nib == psws_pkg::NIB_NOTE_ON && cmd.data_two != 7'd0) begin
					keep     = 1'b1;
					job.kind = psws_pkg::JOB_NOTE_ON;
				end else if (nib == psws_pkg::NIB_NOTE_ON || nib == psws_pkg::NIB_NOTE_OFF) begin
					keep     = 1'b1;
					job.kind = psws_pkg::JOB_NOTE_OFF;
				end
			end
			psws_pkg::OP_FRAME: begin
				keep     = 1'b1;
				job.kind = psws_pkg::JOB_FRAME;
			end
			psws_pkg::OP_ALLOFF: begin
				keep     = 1'b1;
				job.kind = psws_pkg::JOB_ALL_OFF;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = cmd_valid && !cmd_stall && keep;

endmodule

[hw/rtl/psws_fifo.sv]
module psws_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  psws_pkg::job_t  push_job,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output psws_pkg::job_t  head
);

	psws_pkg::job_t                 mem_q [psws_pkg::JOBQ_DEPTH];
	logic [psws_pkg::JOBQ_AW-1:0]   wr_ptr_q;
	logic [psws_pkg::JOBQ_AW-1:0]   rd_ptr_q;
	logic [psws_pkg::JOBQ_AW:0]     count_q;

	assign full      = (count_q == (psws_pkg::JOBQ_AW + 1)'(psws_pkg::JOBQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/psws_engine.sv]
module psws_engine #(
	parameter int VOICES     = 64,
	parameter int PHASE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  psws_pkg::job_t       job,
	output logic                 job_pop,
	output logic                 mix_valid,
	input  logic                 mix_stall,
	output psws_pkg::mix_item_t  mix
);

	localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW     = $clog2(VOICES + 1);
	localparam int RW     = 14 + 2 * PHASE_BITS;
	localparam int SUM_W  = $clog2(VOICES * 127 + 1) + 1;
	localparam int MAG_W  = SUM_W - 1 + 15;
	localparam int RCP_SH = 40;
	localparam int RCP_W  = 30;
	localparam int PROD_W = MAG_W + RCP_W;
	localparam int QW     = PROD_W - RCP_SH;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RCP_SH) / 64'd1270);
	localparam logic [MAG_W-1:0] DIVISOR = MAG_W'(1270);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ON    = 8'b0000_0010,
		S_OFF   = 8'b0000_0100,
		S_FRAME = 8'b0000_1000,
		S_MAG   = 8'b0001_0000,
		S_MUL   = 8'b0010_0000,
		S_FIX   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} eng_state_t;

	eng_state_t                 state_q;
	psws_pkg::job_t             job_q;
	logic [VOICES-1:0]          active_q;
	logic [CW-1:0]              idx_q;
	logic                       v_s1;
	logic [VW-1:0]              idx_s1;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       neg_q;
	logic [MAG_W-1:0]           mag_q;
	logic [PROD_W-1:0]          prod_q;
	logic signed [31:0]         sample_q;
	logic                       out_valid_q;
	psws_pkg::mix_item_t        out_q;

	logic                       ram_we;
	logic [VW-1:0]              ram_waddr;
	logic [RW-1:0]              ram_wdata;
	logic [RW-1:0]              ram_rdata;

	logic [6:0]                 rd_note;
	logic [6:0]                 rd_vel;
	logic [PHASE_BITS-1:0]      rd_inc;
	logic [PHASE_BITS-1:0]      rd_phase;
	logic                       act_s1;
	logic                       issue;
	logic                       cur_free;
	logic signed [SUM_W-1:0]    vel_s;
	logic [SUM_W-1:0]           abs_sum;
	logic [MAG_W-1:0]           abs_w;
	logic [QW-1:0]              q0;
	logic [MAG_W-1:0]           rem;
	logic [QW-1:0]              qf;
	logic [31:0]                qf32;
	logic                       out_load;

	psws_ram #(
		.WIDTH (RW),
		.DEPTH (VOICES)
	) u_voice_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (idx_q[VW-1:0]),
		.rd_data (ram_rdata)
	);

	assign rd_note  = ram_rdata[RW-1 -: 7];
	assign rd_vel   = ram_rdata[RW-8 -: 7];
	assign rd_inc   = ram_rdata[2*PHASE_BITS-1 -: PHASE_BITS];
	assign rd_phase = ram_rdata[PHASE_BITS-1:0];
	assign act_s1   = active_q[idx_s1];
	assign issue    = (idx_q != CW'(VOICES));
	assign cur_free = !active_q[idx_q[VW-1:0]];
	assign vel_s    = signed'(SUM_W'(rd_vel));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = {ram_rdata[RW-1:PHASE_BITS], rd_phase + rd_inc};
		if (state_q == S_ON && cur_free) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q[VW-1:0];
			ram_wdata = {job_q.note, job_q.velocity,
				job_q.inc_q48[psws_pkg::Q48_W-1 -: PHASE_BITS], {PHASE_BITS{1'b0}}};
		end else if (state_q == S_FRAME && v_s1 && act_s1) begin
			ram_we = 1'b1;
		end
	end

	assign abs_sum = sum_q[SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
	assign abs_w   = MAG_W'(abs_sum);
	assign q0      = prod_q[PROD_W-1:RCP_SH];
	assign rem     = mag_q - MAG_W'(q0) * DIVISOR;
	assign qf      = (rem >= DIVISOR) ? q0 + 1'b1 : q0;
	assign qf32    = 32'(qf);

	assign job_pop   = (state_q == S_IDLE) && job_valid;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !mix_stall);
	assign mix_valid = out_valid_q;
	assign mix       = out_q;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		case (state_q)
			S_MAG: begin
				neg_q <= sum_q[SUM_W-1];
				mag_q <= (abs_w << 15) - abs_w;
			end
			S_MUL: begin
				prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP);
			end
			S_FIX: begin
				sample_q <= neg_q ? -signed'(qf32) : signed'(qf32);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.left_out  <= job_q.left_in + sample_q;
			out_q.right_out <= job_q.right_in + sample_q;
		end
		idx_s1 <= idx_q[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!mix_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					v_s1  <= 1'b0;
					sum_q <= '0;
					if (job_pop) begin
						case (job.kind)
							psws_pkg::JOB_NOTE_ON:  state_q <= S_ON;
							psws_pkg::JOB_NOTE_OFF: state_q <= S_OFF;
							psws_pkg::JOB_FRAME:    state_q <= S_FRAME;
							psws_pkg::JOB_ALL_OFF:  active_q <= '0;
							default:                state_q <= S_IDLE;
						endcase
					end
				end
				S_ON: begin
					if (cur_free) begin
						active_q[idx_q[VW-1:0]] <= 1'b1;
						state_q <= S_IDLE;
					end else if (idx_q == CW'(VOICES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_OFF: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					v_s1 <= issue;
					if (v_s1 && act_s1 && rd_note == job_q.note) begin
						active_q[idx_s1] <= 1'b0;
					end
					if (!issue && !v_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_FRAME: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					v_s1 <= issue;
					if (v_s1 && act_s1) begin
						sum_q <= rd_phase[PHASE_BITS-1] ? sum_q - vel_s : sum_q + vel_s;
					end
					if (!issue && !v_s1) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: state_q <= S_MUL;
				S_MUL: state_q <= S_FIX;
				S_FIX: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/polyphonic_square_wave_synth.sv]
// Items pass a classifier and a 4-deep job queue to a voice engine that visits one voice a cycle.
// Frame: a scan of every voice, then the MAG, MUL, FIX and OUT states; one job runs at a time.
// Note-on: scan for the lowest free voice; note-off: a scan of every voice for the key.
// All-off clears every active bit. The voice RAM port (one read, one write a cycle) paces the scans.
// Reset clears the voice active bits, the queue and the output valid bit; voice RAM is not cleared.
module polyphonic_square_wave_synth #(
	parameter int VOICES     = 64,
	parameter int PHASE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  psws_pkg::cmd_item_t  cmd,
	output logic                 mix_valid,
	input  logic                 mix_stall,
	output psws_pkg::mix_item_t  mix
);

	logic            push;
	psws_pkg::job_t  push_job;
	logic            q_full;
	logic            q_not_empty;
	psws_pkg::job_t  q_head;
	logic            q_pop;

	assign cmd_stall = q_full;

	psws_front u_front (
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.push      (push),
		.job       (push_job)
	);

	psws_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	psws_engine #(
		.VOICES     (VOICES),
		.PHASE_BITS (PHASE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (q_head),
		.job_pop   (q_pop),
		.mix_valid (mix_valid),
		.mix_stall (mix_stall),
		.mix       (mix)
	);

endmodule

[bench/mix_checker.sv]
module mix_checker #(
	parameter int VOICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic                cmd_stall,
	input  psws_pkg::cmd_item_t cmd,
	input  logic                mix_valid,
	input  logic                mix_stall,
	input  psws_pkg::mix_item_t mix,
	output int                  errors,
	output int                  pending,
	output int                  frames_checked,
	output int                  notes_dropped,
	output int                  peak_voices
);
	import psws_pkg::*;

	// Q48 phase step of note 0 at 48 kHz
	localparam bit [63:0] C0_STEP_Q48 = 64'd47943391863;

	bit        voice_on   [VOICES];
	bit [6:0]  voice_key  [VOICES];
	bit [6:0]  voice_vel  [VOICES];
	bit [31:0] voice_ph   [VOICES];
	bit [31:0] voice_step [VOICES];
	mix_item_t mix_expected [$];

	// 2^(k/12) in Q24
	function automatic bit [63:0] semitone_q24(input int k);
		case (k)
			0:       return 64'd16777216;
			1:       return 64'd17774841;
			2:       return 64'd18831788;
			3:       return 64'd19951585;
			4:       return 64'd21137968;
			5:       return 64'd22394897;
			6:       return 64'd23726567;
			7:       return 64'd25137422;
			8:       return 64'd26632170;
			9:       return 64'd28215802;
			10:      return 64'd29893600;
			default: return 64'd31671168;
		endcase
	endfunction

	function automatic bit [31:0] key_step(input bit [6:0] key);
		bit [63:0] q48;
		q48 = ((C0_STEP_Q48 * semitone_q24(key % 12)) >> 24) << (key / 12);
		return q48[47:16];
	endfunction

	function automatic int render_level();
		longint total;
		int v;
		total = 0;
		for (v = 0; v < VOICES; v++) begin
			if (voice_on[v]) begin
				if (voice_ph[v][31])
					total = total - longint'(voice_vel[v]);
				else
					total = total + longint'(voice_vel[v]);
				voice_ph[v] = voice_ph[v] + voice_step[v];
			end
		end
		return int'((total * 32767) / 1270);
	endfunction

	task automatic apply_midi(input cmd_item_t c);
		int slot;
		int sounding;
		int v;
		if (c.status_byte[7:4] == NIB_NOTE_ON && c.data_two != 7'd0) begin
			slot = -1;
			for (v = 0; v < VOICES; v++)
				if (!voice_on[v] && slot < 0)
					slot = v;
			if (slot < 0) begin
				notes_dropped++;
			end else begin
				voice_on[slot]   = 1'b1;
				voice_key[slot]  = c.data_one;
				voice_vel[slot]  = c.data_two;
				voice_ph[slot]   = '0;
				voice_step[slot] = key_step(c.data_one);
			end
			sounding = 0;
			for (v = 0; v < VOICES; v++)
				if (voice_on[v])
					sounding++;
			if (sounding > peak_voices)
				peak_voices = sounding;
		end else if (c.status_byte[7:4] == NIB_NOTE_OFF || c.status_byte[7:4] == NIB_NOTE_ON) begin
			for (v = 0; v < VOICES; v++)
				if (voice_on[v] && voice_key[v] == c.data_one)
					voice_on[v] = 1'b0;
		end
	endtask

	task automatic take_cmd(input cmd_item_t c);
		mix_item_t want;
		int level;
		int v;
		case (c.opcode)
			OP_MIDI: begin
				apply_midi(c);
			end
			OP_FRAME: begin
				level = render_level();
				want.left_out  = c.left_in + level;
				want.right_out = c.right_in + level;
				mix_expected.push_back(want);
			end
			OP_ALLOFF: begin
				for (v = 0; v < VOICES; v++)
					voice_on[v] = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_mix(input mix_item_t got);
		mix_item_t want;
		if (mix_expected.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected item: left %0d right %0d", got.left_out, got.right_out);
		end else begin
			want = mix_expected.pop_front();
			frames_checked++;
			if (got.left_out !== want.left_out || got.right_out !== want.right_out) begin
				errors++;
				if (errors <= 10)
					$display("frame %0d: expected left %0d right %0d, got left %0d right %0d",
						frames_checked, want.left_out, want.right_out,
						got.left_out, got.right_out);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++)
				voice_on[v] = 1'b0;
			mix_expected.delete();
		end else begin
			if (cmd_valid && !cmd_stall)
				take_cmd(cmd);
			if (mix_valid && !mix_stall)
				check_mix(mix);
		end
		pending = mix_expected.size();
	end

endmodule

[bench/testbench.sv]
module testbench;
	import psws_pkg::*;

	localparam int VOICES      = 64;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 240;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd = '0;
	logic      mix_valid;
	logic      mix_stall = 1'b0;
	mix_item_t mix;

	int send_idle;
	int recv_stall;
	bit hold_req;
	int cycles;
	int sent;
	bit [6:0] held_keys [$];

	int errors;
	int pending;
	int frames_checked;
	int notes_dropped;
	int peak_voices;

	polyphonic_square_wave_synth #(
		.VOICES(VOICES),
		.PHASE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.mix_valid(mix_valid),
		.mix_stall(mix_stall),
		.mix(mix)
	);

	mix_checker #(
		.VOICES(VOICES)
	) mix_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.mix_valid(mix_valid),
		.mix_stall(mix_stall),
		.mix(mix),
		.errors(errors),
		.pending(pending),
		.frames_checked(frames_checked),
		.notes_dropped(notes_dropped),
		.peak_voices(peak_voices)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				mix_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mix_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("no progress within %0d cycles", CYCLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	function automatic cmd_item_t make_item(input logic [1:0] op, input logic [7:0] status,
			input logic [6:0] key, input logic [6:0] vel,
			input logic [31:0] l, input logic [31:0] r);
		cmd_item_t it;
		it.opcode      = op;
		it.status_byte = status;
		it.data_one    = key;
		it.data_two    = vel;
		it.left_in     = l;
		it.right_in    = r;
		return it;
	endfunction

	function automatic cmd_item_t random_frame();
		return make_item(OP_FRAME, 8'($urandom), 7'($urandom), 7'($urandom), $urandom, $urandom);
	endfunction

	task automatic push_cmd(input cmd_item_t it);
		while ($urandom_range(99) < send_idle) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= it;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sent++;
	endtask

	task automatic drop_key(input bit [6:0] key);
		int at;
		for (at = held_keys.size() - 1; at >= 0; at--)
			if (held_keys[at] == key)
				held_keys.delete(at);
	endtask

	task automatic play_random();
		cmd_item_t it;
		int pick;
		it = make_item(2'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
			$urandom, $urandom);
		pick = $urandom_range(99);
		if (pick < 34) begin
			it.opcode = OP_MIDI;
			it.status_byte[7:4] = NIB_NOTE_ON;
			// a narrow band of keys makes repeated notes common
			if ($urandom_range(1))
				it.data_one = 7'(57 + $urandom_range(7));
			it.data_two = 7'($urandom_range(1, 127));
			held_keys.push_back(it.data_one);
		end else if (pick < 50) begin
			it.opcode = OP_MIDI;
			if (held_keys.size() != 0 && $urandom_range(3) != 0)
				it.data_one = held_keys[$urandom_range(held_keys.size() - 1)];
			if ($urandom_range(1)) begin
				it.status_byte[7:4] = NIB_NOTE_OFF;
			end else begin
				it.status_byte[7:4] = NIB_NOTE_ON;
				it.data_two = '0;
			end
			drop_key(it.data_one);
		end else if (pick < 90) begin
			it.opcode = OP_FRAME;
		end else if (pick < 92) begin
			it.opcode = OP_ALLOFF;
			held_keys.delete();
		end else if (pick < 97) begin
			it.opcode = OP_MIDI;
		end else begin
			it.opcode = OP_SPARE;
		end
		push_cmd(it);
	endtask

	// more note-ons than voices, so the last ones are dropped
	task automatic flood_voices();
		int n;
		for (n = 0; n < VOICES + 6; n++) begin
			push_cmd(make_item(OP_MIDI, {NIB_NOTE_ON, 4'($urandom)}, 7'($urandom),
				7'($urandom_range(1, 127)), $urandom, $urandom));
			held_keys.push_back(cmd.data_one);
		end
		for (n = 0; n < 6; n++)
			push_cmd(random_frame());
		if ($urandom_range(1)) begin
			push_cmd(make_item(OP_ALLOFF, 8'($urandom), 7'($urandom), 7'($urandom),
				$urandom, $urandom));
			held_keys.delete();
		end
	endtask

	initial begin : stimulus
		int ph;
		int n;
		int idle_mode [4];
		int stall_mode [4];
		idle_mode  = '{0, 72, 0, 13};
		stall_mode = '{0, 0, 72, 13};
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, 32'h7FFFFFFF, 32'h80000000));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_ON, 4'h0}, 7'd0, 7'd127, '0, '0));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_ON, 4'hF}, 7'd127, 7'd1, '0, '0));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_ON, 4'h5}, 7'd69, 7'd127, '0, '0));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_ON, 4'h2}, 7'd69, 7'd64, '0, '0));
		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, 32'h7FFFFFFF, 32'h80000000));
		push_cmd(make_item(OP_FRAME, 8'hFF, 7'h7F, 7'h7F, 32'h00000000, 32'hFFFFFFFF));
		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, 32'h80000000, 32'h7FFFFFFF));
		push_cmd(make_item(OP_SPARE, {NIB_NOTE_ON, 4'hF}, 7'h7F, 7'h7F, '1, '1));
		push_cmd(make_item(OP_MIDI, 8'hA3, 7'd69, 7'd127, '0, '0));
		push_cmd(make_item(OP_MIDI, 8'hFF, 7'd0, 7'd0, '0, '0));
		push_cmd(make_item(OP_MIDI, 8'h00, 7'd127, 7'd127, '0, '0));
		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, 32'h12345678, 32'hEDCBA987));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_OFF, 4'h0}, 7'd69, 7'd127, '0, '0));
		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, '0, '0));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_ON, 4'h0}, 7'd0, 7'd0, '0, '0));
		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, '0, '0));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_OFF, 4'hF}, 7'd127, 7'd0, '0, '0));
		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, 32'h7FFFFFFF, 32'h80000000));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_ON, 4'h9}, 7'd60, 7'd100, '0, '0));
		push_cmd(make_item(OP_MIDI, {NIB_NOTE_ON, 4'h9}, 7'd72, 7'd127, '0, '0));
		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, '1, '1));
		push_cmd(make_item(OP_ALLOFF, 8'h00, 7'd0, 7'd0, '0, '0));
		push_cmd(make_item(OP_FRAME, 8'h00, 7'd0, 7'd0, '0, '0));

		for (ph = 0; ph < 4; ph++) begin
			send_idle  = idle_mode[ph];
			recv_stall = stall_mode[ph];
			if (ph == 2) begin
				// receiver held off while frames keep coming: queue fills, input stalls
				send_idle = 0;
				hold_req  = 1'b1;
				for (n = 0; n < 16; n++)
					push_cmd(random_frame());
				send_idle = idle_mode[ph];
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					flood_voices();
				play_random();
			end
		end

		cmd_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (6 * (VOICES + 8)) @(posedge clk);

		$display("%0d items sent, %0d frames compared, %0d note-ons found no free voice",
			sent, frames_checked, notes_dropped);
		$display("up to %0d voices sounding at once, %0d bad or unexpected results",
			peak_voices, errors);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/psws_pkg.sv
hw/rtl/psws_ram.sv
hw/rtl/psws_front.sv
hw/rtl/psws_fifo.sv
hw/rtl/psws_engine.sv
hw/rtl/polyphonic_square_wave_synth.sv
bench/mix_checker.sv
bench/testbench.sv
